// File: rtl/swm_pkg.sv
`default_nettype none

package swm_pkg;

  // window limit and derived sizes
  localparam int WindowMax = 16;
  localparam int DeqDepth  = WindowMax + 1;
  localparam int DataW     = 32;
  localparam int CfgW      = 5;
  localparam int IdxW      = $clog2(DeqDepth);
  localparam int CntW      = $clog2(DeqDepth + 1);
  localparam int SumW      = CntW + 1;
  localparam int WinW      = $clog2(WindowMax + 1);
  localparam int RecW      = (WindowMax > 1) ? $clog2(WindowMax) : 1;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BACK_RD,
    ST_BACK_CMP,
    ST_PUSH,
    ST_FRONT_RD,
    ST_FRONT_CMP,
    ST_REREAD,
    ST_DONE
  } state_e;

  // deque commands, at most one per cycle
  typedef struct packed {
    logic clear;
    logic rd_back;
    logic rd_front;
    logic drop_back;
    logic push;
    logic drop_front;
  } deq_cmd_t;

  // circular slot index: base plus offset, wrapped at the deque depth
  function automatic logic [IdxW-1:0] deq_slot(input logic [IdxW-1:0] base,
                                               input logic [CntW-1:0] off);
    logic [SumW-1:0] sum;
    sum = SumW'(base) + SumW'(off);
    if (sum >= SumW'(DeqDepth)) begin
      sum = sum - SumW'(DeqDepth);
    end
    return sum[IdxW-1:0];
  endfunction

  // window length clamped into 1..WindowMax
  function automatic logic [WinW-1:0] eff_window(input logic [CfgW-1:0] ws);
    logic [WinW-1:0] res;
    if (ws == '0) begin
      res = WinW'(1);
    end else if (int'(ws) > WindowMax) begin
      res = WinW'(WindowMax);
    end else begin
      res = WinW'(ws);
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// File: rtl/swm_deque.sv
`default_nettype none

module swm_deque (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire swm_pkg::deq_cmd_t            cmd_i,
  input  wire logic [swm_pkg::DataW-1:0]    wdata_i,
  output logic [swm_pkg::DataW-1:0]         rdata_o,
  output logic [swm_pkg::CntW-1:0]          count_o
);

  logic [swm_pkg::DataW-1:0] mem [swm_pkg::DeqDepth];
  logic [swm_pkg::DataW-1:0] rdata_q;
  logic [swm_pkg::IdxW-1:0]  head_q, head_d;
  logic [swm_pkg::CntW-1:0]  count_q, count_d;
  logic [swm_pkg::IdxW-1:0]  head_push;
  logic [swm_pkg::CntW-1:0]  cnt_push;
  logic                      wr_en;
  logic [swm_pkg::IdxW-1:0]  wr_addr;
  logic                      rd_en;
  logic [swm_pkg::IdxW-1:0]  rd_addr;

  // room for a push: a full deque loses its front first
  always_comb begin
    if (count_q == swm_pkg::CntW'(swm_pkg::DeqDepth)) begin
      head_push = swm_pkg::deq_slot(head_q, swm_pkg::CntW'(1));
      cnt_push  = swm_pkg::CntW'(swm_pkg::DeqDepth - 1);
    end else begin
      head_push = head_q;
      cnt_push  = count_q;
    end
  end

  // head and count update
  always_comb begin
    head_d  = head_q;
    count_d = count_q;
    wr_en   = 1'b0;
    wr_addr = head_q;
    if (cmd_i.clear) begin
      head_d  = '0;
      count_d = '0;
    end else if (cmd_i.drop_back) begin
      count_d = count_q - swm_pkg::CntW'(1);
    end else if (cmd_i.push) begin
      wr_en   = 1'b1;
      wr_addr = swm_pkg::deq_slot(head_push, cnt_push);
      head_d  = head_push;
      count_d = cnt_push + swm_pkg::CntW'(1);
    end else if (cmd_i.drop_front) begin
      head_d  = swm_pkg::deq_slot(head_q, swm_pkg::CntW'(1));
      count_d = count_q - swm_pkg::CntW'(1);
    end
  end

  // read address: back entry or front entry
  assign rd_en   = cmd_i.rd_back | cmd_i.rd_front;
  assign rd_addr = cmd_i.rd_back ? swm_pkg::deq_slot(head_q, count_q - swm_pkg::CntW'(1))
                                 : head_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      count_q <= '0;
    end else begin
      head_q  <= head_d;
      count_q <= count_d;
    end
  end

  // value store, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wdata_i;
    end
    if (rd_en) begin
      rdata_q <= mem[rd_addr];
    end
  end

  assign rdata_o = rdata_q;
  assign count_o = count_q;

endmodule

`default_nettype wire

// File: rtl/sliding_window_max.sv
// Running maximum of the last window_size signed 32-bit samples (1..16, 0 acts
// as 1, larger values as 16), kept as a monotonic deque of candidates in a
// 17-entry value store with one registered read port. A sample with
// start_req_i set opens a new sequence and empties the window. The first
// window_size - 1 samples of a sequence give no result; every later sample
// gives one window_max_o transaction. A sample is taken only while idle; the
// sequencer then reads the back entry and drops it while smaller, reading
// again until no entry is left or the back is not smaller, pushes the sample,
// reads the front, drops it and rereads it when it is the leaving sample, and
// waits while a result is held for the receiver. The store's single read port
// sets this pace, walked one entry at a time through the shared compare. The
// user must write window_size only while idle; the block does not enforce it.
`default_nettype none

module sliding_window_max (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             window_size_we_i,
  input  wire logic [swm_pkg::CfgW-1:0]         window_size_i,
  input  wire logic                             in_valid_i,
  output logic                                  in_ready_o,
  input  wire logic signed [swm_pkg::DataW-1:0] sample_i,
  input  wire logic                             start_req_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_ready_i,
  output logic signed [swm_pkg::DataW-1:0]      window_max_o
);

  swm_pkg::state_e                 state_q, state_d;
  swm_pkg::deq_cmd_t               cmd;
  logic [swm_pkg::CfgW-1:0]        window_size_q;
  logic signed [swm_pkg::DataW-1:0] sample_q;
  logic [swm_pkg::WinW-1:0]        k_q;
  logic [swm_pkg::WinW-1:0]        seen_q;
  logic signed [swm_pkg::DataW-1:0] recent_q [swm_pkg::WindowMax];
  logic signed [swm_pkg::DataW-1:0] out_data_q;
  logic                            out_valid_q;
  logic [swm_pkg::DataW-1:0]       rdata;
  logic [swm_pkg::CntW-1:0]        count;
  logic [swm_pkg::WinW-1:0]        k_m1;
  logic [swm_pkg::RecW-1:0]        rec_idx;
  logic [swm_pkg::WinW:0]          seen_inc;
  logic                            emit;
  logic                            accept;
  logic                            back_smaller;
  logic                            front_leaves;
  logic                            out_stall;
  logic                            advance;
  logic                            load_out;

  swm_deque u_deque (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (cmd),
    .wdata_i (sample_q),
    .rdata_o (rdata),
    .count_o (count)
  );

  assign accept = in_valid_i & in_ready_o;

  // shared compare against the entry just read
  assign back_smaller = $signed(rdata) < sample_q;
  assign k_m1         = k_q - swm_pkg::WinW'(1);
  assign rec_idx      = k_m1[swm_pkg::RecW-1:0];
  assign front_leaves = (seen_q >= k_q) && (count >= swm_pkg::CntW'(2)) &&
                        (recent_q[rec_idx] == $signed(rdata));

  // result decision and seen count
  assign seen_inc  = {1'b0, seen_q} + (swm_pkg::WinW + 1)'(1);
  assign emit      = seen_inc >= {1'b0, k_q};
  assign out_stall = out_valid_q & ~out_ready_i;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      swm_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = swm_pkg::ST_BACK_RD;
        end
      end
      swm_pkg::ST_BACK_RD: begin
        state_d = (count != '0) ? swm_pkg::ST_BACK_CMP : swm_pkg::ST_PUSH;
      end
      swm_pkg::ST_BACK_CMP: begin
        state_d = back_smaller ? swm_pkg::ST_BACK_RD : swm_pkg::ST_PUSH;
      end
      swm_pkg::ST_PUSH: begin
        state_d = swm_pkg::ST_FRONT_RD;
      end
      swm_pkg::ST_FRONT_RD: begin
        state_d = swm_pkg::ST_FRONT_CMP;
      end
      swm_pkg::ST_FRONT_CMP: begin
        state_d = front_leaves ? swm_pkg::ST_REREAD : swm_pkg::ST_DONE;
      end
      swm_pkg::ST_REREAD: begin
        state_d = swm_pkg::ST_DONE;
      end
      swm_pkg::ST_DONE: begin
        if (!(emit && out_stall)) begin
          state_d = swm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = swm_pkg::ST_IDLE;
      end
    endcase
  end

  // sequencer outputs
  always_comb begin
    cmd        = '0;
    in_ready_o = 1'b0;
    advance    = 1'b0;
    load_out   = 1'b0;
    case (state_q)
      swm_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd.clear  = in_valid_i & start_req_i;
      end
      swm_pkg::ST_BACK_RD: begin
        cmd.rd_back = (count != '0);
      end
      swm_pkg::ST_BACK_CMP: begin
        cmd.drop_back = back_smaller;
      end
      swm_pkg::ST_PUSH: begin
        cmd.push = 1'b1;
      end
      swm_pkg::ST_FRONT_RD: begin
        cmd.rd_front = 1'b1;
      end
      swm_pkg::ST_FRONT_CMP: begin
        cmd.drop_front = front_leaves;
      end
      swm_pkg::ST_REREAD: begin
        cmd.rd_front = 1'b1;
      end
      swm_pkg::ST_DONE: begin
        advance  = !(emit && out_stall);
        load_out = emit && !out_stall;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= swm_pkg::ST_IDLE;
      window_size_q <= swm_pkg::CfgW'(1);
      seen_q        <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      if (window_size_we_i) begin
        window_size_q <= window_size_i;
      end
      if (accept && start_req_i) begin
        seen_q <= '0;
      end else if (advance) begin
        seen_q <= emit ? k_q : seen_inc[swm_pkg::WinW-1:0];
      end
      out_valid_q <= out_stall | load_out;
    end
  end

  // sample capture, past samples and result register
  always_ff @(posedge clk_i) begin
    if (accept) begin
      sample_q <= sample_i;
      k_q      <= swm_pkg::eff_window(window_size_q);
    end
    if (advance) begin
      for (int i = swm_pkg::WindowMax - 1; i > 0; i--) begin
        recent_q[i] <= recent_q[i-1];
      end
      recent_q[0] <= sample_q;
    end
    if (load_out) begin
      out_data_q <= $signed(rdata);
    end
  end

  assign out_valid_o  = out_valid_q;
  assign window_max_o = out_data_q;

endmodule

`default_nettype wire
